### design/pdm_pkg.sv
// ============================================================================
// PID derivative-on-measurement package
// Shared widths, configuration register indexes, state and command types for
// the controller, the datapath and the register bank.
// ============================================================================
`default_nettype none

package pdm_pkg;

    // Sample width of the setpoint and feedback fields.
    localparam int SAMPLE_WIDTH = 16;

    localparam int GAIN_W   = 16;
    localparam int ERR_W    = SAMPLE_WIDTH + 1;
    localparam int ILIM_W   = 47;
    localparam int ACC_W    = 48;
    localparam int DRIVE_W  = 48;
    localparam int FRAC_SH  = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ILIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd6;

    localparam logic [GAIN_W-1:0] RST_PROP_GAIN      = 16'd256;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN     = 16'd0;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN     = 16'd0;
    localparam logic [GAIN_W-1:0] RST_PERIOD         = 16'd655;
    localparam logic [GAIN_W-1:0] RST_INVERSE_PERIOD = 16'd100;
    localparam logic [GAIN_W-1:0] RST_ERROR_LIMIT    = 16'hFFFF;
    localparam logic [ILIM_W-1:0] RST_INTEGRAL_LIMIT = '1;

    // Shared multiplier: a signed A operand by a 17-bit signed B operand.
    localparam int T_W    = GAIN_W + ERR_W;
    localparam int A_W    = T_W;
    localparam int B_W    = GAIN_W + 1;
    localparam int PROD_W = A_W + B_W;

    // Integral increment after the Q.24 to Q.16 shift, and the accumulator sum.
    localparam int INC_W  = T_W + GAIN_W - FRAC_SH;
    localparam int SUM_W  = ((ACC_W > INC_W) ? ACC_W : INC_W) + 1;

    // Derivative magnitude in Q.8, its cap of 2^48 and the capped widths.
    localparam int DM_W     = 2 * GAIN_W + SAMPLE_WIDTH;
    localparam int DCAP_BIT = 48;
    localparam int DCAP_W   = DCAP_BIT + 1;
    localparam int DMX_W    = (DM_W > DCAP_W) ? DM_W : DCAP_W;
    localparam int D_W      = DCAP_W + FRAC_SH + 1;

    // Proportional term, P + D partial sum and full drive sum.
    localparam int P_W    = T_W;
    localparam int PQ_W   = P_W + FRAC_SH;
    localparam int PD_W   = ((PQ_W > D_W) ? PQ_W : D_W) + 1;
    localparam int DS_W   = ((PD_W > ACC_W) ? PD_W : ACC_W) + 1;

    // Compare width for the error clamp.
    localparam int CMP_W  = ((ERR_W > GAIN_W + 1) ? ERR_W : GAIN_W + 1) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_I1,
        S_MUL_I2,
        S_MUL_D1,
        S_MUL_D2,
        S_CLAMP,
        S_SUM
    } t_state;

    typedef enum logic [2:0] {
        MUL_P,
        MUL_I1,
        MUL_I2,
        MUL_D1,
        MUL_D2
    } t_mul_op;

    typedef struct packed {
        logic    load_in;
        logic    mul_en;
        t_mul_op mul_op;
        logic    clamp_err;
        logic    acc_add;
        logic    acc_clamp;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [GAIN_W-1:0] period;
        logic [GAIN_W-1:0] inverse_period;
        logic [GAIN_W-1:0] error_limit;
        logic [ILIM_W-1:0] integral_limit;
    } t_cfg;

endpackage

`default_nettype wire

### design/pdm_cfg.sv
// ============================================================================
// PID configuration register bank
// Holds the gains, period, rate and clamp limits written through the port.
// ============================================================================
`default_nettype none

module pdm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pdm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pdm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output pdm_pkg::t_cfg                    o_cfg
);
    import pdm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PROP_GAIN:      n_cfg.prop_gain      = i_cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:     n_cfg.integ_gain     = i_cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:     n_cfg.deriv_gain     = i_cfg_data[GAIN_W-1:0];
                REG_PERIOD:         n_cfg.period         = i_cfg_data[GAIN_W-1:0];
                REG_INVERSE_PERIOD: n_cfg.inverse_period = i_cfg_data[GAIN_W-1:0];
                REG_ERROR_LIMIT:    n_cfg.error_limit    = i_cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: n_cfg.integral_limit = i_cfg_data[ILIM_W-1:0];
                default: begin
                    // Writes to unused indexes are dropped.
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain      <= RST_PROP_GAIN;
            r_cfg.integ_gain     <= RST_INTEG_GAIN;
            r_cfg.deriv_gain     <= RST_DERIV_GAIN;
            r_cfg.period         <= RST_PERIOD;
            r_cfg.inverse_period <= RST_INVERSE_PERIOD;
            r_cfg.error_limit    <= RST_ERROR_LIMIT;
            r_cfg.integral_limit <= RST_INTEGRAL_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/pdm_ctrl.sv
// ============================================================================
// PID sequencer
// Steps the datapath through the multiply, clamp and sum phases of a sample
// and owns the valid flag of the result register.
// ============================================================================
`default_nettype none

module pdm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output pdm_pkg::t_dp_cmd o_cmd
);
    import pdm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    t_dp_cmd cmd;

    // The result register can take a new value when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_MUL_P;
            S_MUL_P:  n_state = S_MUL_I1;
            S_MUL_I1: n_state = S_MUL_I2;
            S_MUL_I2: n_state = S_MUL_D1;
            S_MUL_D1: n_state = S_MUL_D2;
            S_MUL_D2: n_state = S_CLAMP;
            S_CLAMP:  n_state = S_SUM;
            S_SUM:    if (out_free) n_state = S_IDLE;
        endcase
    end

    always_comb begin
        cmd           = '0;
        cmd.mul_op    = MUL_P;
        unique case (r_state)
            S_IDLE: begin
                cmd.load_in = i_in_valid;
            end
            S_MUL_P: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_op    = MUL_P;
                cmd.clamp_err = 1'b1;
            end
            S_MUL_I1: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_I1;
            end
            S_MUL_I2: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_I2;
            end
            S_MUL_D1: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_D1;
            end
            S_MUL_D2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_op  = MUL_D2;
                cmd.acc_add = 1'b1;
            end
            S_CLAMP: begin
                cmd.acc_clamp = 1'b1;
            end
            S_SUM: begin
                cmd.load_out = out_free;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

### design/pdm_dp.sv
// ============================================================================
// PID datapath
// One shared multiplier, the integral accumulator with its clamps, the
// derivative cap and the saturating drive sum, with the result register.
// ============================================================================
`default_nettype none

module pdm_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  pdm_pkg::t_dp_cmd                        i_cmd,
    input  pdm_pkg::t_cfg                           i_cfg,
    input  logic signed [pdm_pkg::SAMPLE_WIDTH-1:0] i_setpoint,
    input  logic signed [pdm_pkg::SAMPLE_WIDTH-1:0] i_feedback,
    output logic signed [pdm_pkg::DRIVE_W-1:0]      o_drive,
    output logic signed [pdm_pkg::ERR_W-1:0]        o_control_error,
    output logic signed [pdm_pkg::ACC_W-1:0]        o_integral_term
);
    import pdm_pkg::*;

    localparam logic [DMX_W-1:0] D_CAP = DMX_W'(1) << DCAP_BIT;

    // Sample state.
    logic signed [SAMPLE_WIDTH-1:0] r_last_fb;
    logic signed [ACC_W-1:0]        r_integral;
    logic signed [ACC_W-1:0]        n_integral;

    // Working registers.
    logic signed [ERR_W-1:0] r_err;
    logic signed [ERR_W-1:0] r_delta;
    logic signed [ERR_W-1:0] r_cerr;
    logic signed [ERR_W-1:0] n_cerr;
    logic signed [P_W-1:0]   r_p;
    logic signed [T_W-1:0]   r_t;
    logic signed [INC_W-1:0] r_inc;
    logic        [DM_W-1:0]  r_dm;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [PD_W-1:0]  r_pd;
    logic signed [PD_W-1:0]  n_pd;

    // Result register.
    logic signed [DRIVE_W-1:0] r_drive;
    logic signed [DRIVE_W-1:0] n_drive;
    logic signed [ERR_W-1:0]   r_err_out;
    logic signed [ACC_W-1:0]   r_int_out;

    // Multiplier.
    logic signed [A_W-1:0]    mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [SAMPLE_WIDTH-1:0]  delta_mag;
    logic signed [ERR_W-1:0]  delta_neg;

    // Error clamp.
    logic signed [CMP_W-1:0] err_x;
    logic signed [CMP_W-1:0] elim_pos;
    logic signed [CMP_W-1:0] elim_neg;

    // Integral clamp.
    logic signed [SUM_W-1:0] ilim_pos;
    logic signed [SUM_W-1:0] ilim_neg;
    logic signed [SUM_W-1:0] sum_clamped;

    // Derivative and proportional terms.
    logic [DMX_W-1:0]         dm_x;
    logic [DMX_W-1:0]         dm_capped;
    logic [DCAP_W+FRAC_SH-1:0] d_mag_q16;
    logic signed [D_W-1:0]    d_pos;
    logic signed [D_W-1:0]    d_val;
    logic signed [PQ_W-1:0]   p_q16;
    logic                     delta_pos;

    // Drive sum.
    logic signed [DS_W-1:0]        drv_sum;
    logic [DS_W-DRIVE_W:0]         drv_top;

    assign delta_neg = -r_delta;
    assign delta_mag = r_delta[ERR_W-1] ? delta_neg[SAMPLE_WIDTH-1:0]
                                        : r_delta[SAMPLE_WIDTH-1:0];

    always_comb begin
        unique case (i_cmd.mul_op)
            MUL_P: begin
                mul_a = A_W'(r_err);
                mul_b = $signed({1'b0, i_cfg.prop_gain});
            end
            MUL_I1: begin
                mul_a = A_W'(r_cerr);
                mul_b = $signed({1'b0, i_cfg.integ_gain});
            end
            MUL_I2: begin
                mul_a = r_t;
                mul_b = $signed({1'b0, i_cfg.period});
            end
            MUL_D1: begin
                mul_a = $signed(A_W'(delta_mag));
                mul_b = $signed({1'b0, i_cfg.deriv_gain});
            end
            MUL_D2: begin
                mul_a = r_t;
                mul_b = $signed({1'b0, i_cfg.inverse_period});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Error clamp to plus or minus the error limit.
    assign err_x    = CMP_W'(r_err);
    assign elim_pos = $signed(CMP_W'(i_cfg.error_limit));
    assign elim_neg = -elim_pos;

    always_comb begin
        priority if (err_x > elim_pos) begin
            n_cerr = elim_pos[ERR_W-1:0];
        end else if (err_x < elim_neg) begin
            n_cerr = elim_neg[ERR_W-1:0];
        end else begin
            n_cerr = r_err;
        end
    end

    // Integral clamp to plus or minus the integral limit.
    assign ilim_pos = $signed(SUM_W'(i_cfg.integral_limit));
    assign ilim_neg = -ilim_pos;

    always_comb begin
        priority if (r_sum > ilim_pos) begin
            sum_clamped = ilim_pos;
        end else if (r_sum < ilim_neg) begin
            sum_clamped = ilim_neg;
        end else begin
            sum_clamped = r_sum;
        end
    end

    assign n_integral = sum_clamped[ACC_W-1:0];

    // Derivative: capped magnitude, negated when the feedback has risen.
    assign dm_x      = DMX_W'(r_dm);
    assign dm_capped = (dm_x > D_CAP) ? D_CAP : dm_x;
    assign d_mag_q16 = {dm_capped[DCAP_W-1:0], {FRAC_SH{1'b0}}};
    assign d_pos     = $signed({1'b0, d_mag_q16});
    assign delta_pos = !r_delta[ERR_W-1] && (r_delta != '0);
    assign d_val     = delta_pos ? -d_pos : d_pos;
    assign p_q16     = $signed({r_p, {FRAC_SH{1'b0}}});
    assign n_pd      = PD_W'(p_q16) + PD_W'(d_val);

    // Drive: P + D + I, saturated to the drive width.
    assign drv_sum = DS_W'(r_pd) + DS_W'(r_integral);
    assign drv_top = drv_sum[DS_W-1:DRIVE_W-1];

    always_comb begin
        priority if ((drv_top == '0) || (drv_top == '1)) begin
            n_drive = drv_sum[DRIVE_W-1:0];
        end else if (drv_sum[DS_W-1]) begin
            n_drive = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            n_drive = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_fb  <= '0;
            r_integral <= '0;
        end else begin
            if (i_cmd.load_in) begin
                r_last_fb <= i_feedback;
            end
            if (i_cmd.acc_clamp) begin
                r_integral <= n_integral;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_err   <= ERR_W'(i_setpoint) - ERR_W'(i_feedback);
            r_delta <= ERR_W'(i_feedback) - ERR_W'(r_last_fb);
        end
        if (i_cmd.clamp_err) begin
            r_cerr <= n_cerr;
        end
        if (i_cmd.mul_en && (i_cmd.mul_op == MUL_P)) begin
            r_p <= prod[P_W-1:0];
        end
        if (i_cmd.mul_en && ((i_cmd.mul_op == MUL_I1) || (i_cmd.mul_op == MUL_D1))) begin
            r_t <= prod[T_W-1:0];
        end
        if (i_cmd.mul_en && (i_cmd.mul_op == MUL_I2)) begin
            // Arithmetic shift: Q.24 to Q.16, rounding toward minus infinity.
            r_inc <= prod[T_W+GAIN_W-1:FRAC_SH];
        end
        if (i_cmd.mul_en && (i_cmd.mul_op == MUL_D2)) begin
            r_dm <= prod[DM_W-1:0];
        end
        if (i_cmd.acc_add) begin
            r_sum <= SUM_W'(r_integral) + SUM_W'(r_inc);
        end
        if (i_cmd.acc_clamp) begin
            r_pd <= n_pd;
        end
        if (i_cmd.load_out) begin
            r_drive   <= n_drive;
            r_err_out <= r_err;
            r_int_out <= r_integral;
        end
    end

    assign o_drive         = r_drive;
    assign o_control_error = r_err_out;
    assign o_integral_term = r_int_out;

endmodule

`default_nettype wire

### design/pid_derivative_on_measurement.sv
// ============================================================================
// PID controller with derivative on measurement
// Top level: register bank, sequencer and shared-multiplier datapath.
// ============================================================================
// Each accepted request carries one setpoint and one feedback sample and
// yields one result: the saturated Q32.16 drive value, the unclamped error
// (setpoint minus feedback) and the integral accumulator after this sample.
// A sample occupies the block from the accepting cycle through five
// passes through the single shared 33 by 17 bit multiplier (proportional
// product, the two integral products, the two derivative products), the
// integral clamp with the P plus D sum, and the saturating drive sum.
// The next request is taken in the cycle after the result has
// been written to the output register, so a result waiting on a stalled
// consumer does not hold up the following sample until that sample itself
// reaches its final sum. There is no clearing pass after reset: the
// integral accumulator and the previous feedback sample reset to zero.
// Configuration registers may only be written while the block is idle.
// Writing zero to the inverse period turns the derivative term off, and a
// zero integral limit holds the integral at zero.
// ============================================================================
`default_nettype none

module pid_derivative_on_measurement (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Sample request channel.
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [pdm_pkg::SAMPLE_WIDTH-1:0] i_setpoint,
    input  logic signed [pdm_pkg::SAMPLE_WIDTH-1:0] i_feedback,
    // Result channel.
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [pdm_pkg::DRIVE_W-1:0]      o_drive,
    output logic signed [pdm_pkg::ERR_W-1:0]        o_control_error,
    output logic signed [pdm_pkg::ACC_W-1:0]        o_integral_term,
    // Configuration write port.
    input  logic                                    i_cfg_we,
    input  logic [pdm_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [pdm_pkg::CFG_DATA_W-1:0]          i_cfg_data
);
    import pdm_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;

    // Software-visible gains, period, rate and limits.
    pdm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The sequencer decides which product the multiplier forms each cycle.
    pdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // The datapath keeps the integral and previous feedback between samples.
    pdm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg           (cfg),
        .i_setpoint      (i_setpoint),
        .i_feedback      (i_feedback),
        .o_drive         (o_drive),
        .o_control_error (o_control_error),
        .o_integral_term (o_integral_term)
    );

endmodule

`default_nettype wire

### design/pdm_checker.sv
// ============================================================================
// PID port checker
// Watches the top-level handshakes and the sequencing they imply.
// ============================================================================
`default_nettype none

module pdm_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    i_in_valid,
    input logic                                    i_in_stall,
    input logic                                    i_out_valid,
    input logic                                    i_out_stall,
    input logic signed [pdm_pkg::DRIVE_W-1:0]      i_drive,
    input logic signed [pdm_pkg::ERR_W-1:0]        i_control_error,
    input logic signed [pdm_pkg::ACC_W-1:0]        i_integral_term
);

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> ($stable(i_drive) &&
            $stable(i_control_error) && $stable(i_integral_term)))
        else $error("result changed while stalled");

    // Only one sample is in progress at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_stall) |=> i_in_stall)
        else $error("second request taken while a sample is in progress");

    // A sample cannot produce its result in the cycle after it is taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_stall && !i_out_valid) |=> !i_out_valid)
        else $error("result appeared too early");

    // A new result only appears at the end of a sample in progress.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_stall))
        else $error("result appeared with no sample in progress");

endmodule

bind pid_derivative_on_measurement pdm_checker u_pdm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .i_in_stall      (o_in_stall),
    .i_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .i_drive         (o_drive),
    .i_control_error (o_control_error),
    .i_integral_term (o_integral_term)
);

`default_nettype wire
